>>> hdl/jkvs_pkg.sv
package jkvs_pkg;

    localparam int MAX_BUFFER = 4096;
    localparam int MAX_DEPTH  = 63;

    // offsets as reported on the result port
    localparam int OFFSET_W = 12;
    // byte counter must hold MAX_BUFFER itself
    localparam int COUNT_W  = $clog2(MAX_BUFFER + 1);
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
    localparam int PHASE_W  = 4;
    localparam int STATUS_W = 4;
    localparam int KIND_W   = 2;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [KIND_W-1:0]   kind_t;

    localparam phase_t PH_NAME             = 4'd0;
    localparam phase_t PH_NAME_AFTER_COMMA = 4'd1;
    localparam phase_t PH_IN_NAME          = 4'd2;
    localparam phase_t PH_COLON            = 4'd3;
    localparam phase_t PH_VALUE            = 4'd4;
    localparam phase_t PH_STRING           = 4'd5;
    localparam phase_t PH_ARRAY            = 4'd6;
    localparam phase_t PH_STRUCT           = 4'd7;
    localparam phase_t PH_NUMBER           = 4'd8;

    localparam status_t ST_FOUND          = 4'd0;
    localparam status_t ST_NO_PARAM       = 4'd1;
    localparam status_t ST_NAME_OPEN      = 4'd2;
    localparam status_t ST_NO_COLON       = 4'd3;
    localparam status_t ST_NO_VALUE       = 4'd4;
    localparam status_t ST_BAD_VALUE      = 4'd5;
    localparam status_t ST_STRING_OPEN    = 4'd6;
    localparam status_t ST_ARRAY_OPEN     = 4'd7;
    localparam status_t ST_STRUCT_OPEN    = 4'd8;
    localparam status_t ST_NUMBER_OPEN    = 4'd9;
    localparam status_t ST_DELIM_IN_STR   = 4'd10;
    localparam status_t ST_SECOND_DOT     = 4'd11;
    localparam status_t ST_OVERFLOW       = 4'd12;

    localparam kind_t KIND_STRING = 2'd0;
    localparam kind_t KIND_ARRAY  = 2'd1;
    localparam kind_t KIND_STRUCT = 2'd2;
    localparam kind_t KIND_NUMBER = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        status_t status;
        kind_t   value_kind;
        offset_t name_begin;
        offset_t name_end;
        offset_t value_begin;
        offset_t value_end;
        logic    final_result;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) ||
               (c == CH_NUL) || (c == CH_TAB);
    endfunction

    function automatic status_t end_status(input phase_t ph);
        status_t st;
        case (ph)
            PH_IN_NAME: st = ST_NAME_OPEN;
            PH_COLON:   st = ST_NO_COLON;
            PH_VALUE:   st = ST_NO_VALUE;
            PH_STRING:  st = ST_STRING_OPEN;
            PH_ARRAY:   st = ST_ARRAY_OPEN;
            PH_STRUCT:  st = ST_STRUCT_OPEN;
            PH_NUMBER:  st = ST_NUMBER_OPEN;
            default:    st = ST_NO_PARAM;
        endcase
        return st;
    endfunction

    // final status transaction: all offsets and the kind read as zero
    function automatic result_t fail_result(input status_t st);
        result_t r;
        r = '0;
        r.status = st;
        r.final_result = 1'b1;
        return r;
    endfunction

endpackage

>>> hdl/jkvs_in_if.sv
interface jkvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source(output valid, data_byte, first_byte, last_byte, input ready);
    modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

>>> hdl/jkvs_out_if.sv
interface jkvs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [1:0]  value_kind;
    logic [11:0] name_begin;
    logic [11:0] name_end;
    logic [11:0] value_begin;
    logic [11:0] value_end;
    logic        final_result;

    modport source(output valid, status, value_kind, name_begin, name_end,
                   value_begin, value_end, final_result, input ready);
    modport sink(input valid, status, value_kind, name_begin, name_end,
                 value_begin, value_end, final_result, output ready);
endinterface

>>> hdl/json_key_value_scanner_core.sv
// a result is written into the result queue when its byte is accepted and is shown from the queue head
// throughput: one byte per cycle while data.ready is high; the byte that both closes a parameter and ends
// the buffer yields two result transactions, drained one per cycle while result.ready is high
// a four-entry result queue lets input run on while output is stalled, until it holds more than two entries
// reset: scan state returns to waiting for a name at offset zero, queue empty
module json_key_value_scanner_core
(
    input  logic          clk,
    input  logic          rst_n,
    jkvs_in_if.sink       data,
    jkvs_out_if.source    result
);
    import jkvs_pkg::*;

    phase_t  phase_reg,  phase_next;
    count_t  offset_reg, offset_next;
    offset_t nb_reg,     nb_next;
    offset_t ne_reg,     ne_next;
    offset_t vb_reg,     vb_next;
    depth_t  depth_reg,  depth_next;
    logic    dot_reg,    dot_next;
    logic    stopped_reg, stopped_next;

    result_t q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] count_reg;

    logic    accept;
    logic    pop;
    logic [1:0] push_n;
    result_t res0, res1, res_new;
    status_t err;
    count_t  off;
    logic [7:0] c;
    logic    have_new;

    assign accept = data.valid && data.ready;
    assign pop    = result.valid && result.ready;
    // room for the worst case of two results
    assign data.ready = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign c = data.data_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        nb_next      = nb_reg;
        ne_next      = ne_reg;
        vb_next      = vb_reg;
        depth_next   = depth_reg;
        dot_next     = dot_reg;
        stopped_next = stopped_reg;
        res0         = '0;
        res1         = '0;
        push_n       = 2'd0;
        err          = ST_FOUND;
        off          = '0;
        have_new     = 1'b0;
        res_new      = '0;

        if (accept)
        begin
            if (data.first_byte)
            begin
                phase_next   = PH_NAME;
                offset_next  = '0;
                nb_next      = '0;
                ne_next      = '0;
                vb_next      = '0;
                depth_next   = '0;
                dot_next     = 1'b0;
                stopped_next = 1'b0;
            end
            if (!stopped_next)
            begin
                off = offset_next;
                if (off >= COUNT_W'(MAX_BUFFER))
                begin
                    res0 = fail_result(ST_OVERFLOW);
                    push_n = 2'd1;
                    stopped_next = 1'b1;
                end
                else
                begin
                    offset_next = off + 1'b1;
                    res_new.name_begin  = nb_next;
                    res_new.name_end    = ne_next;
                    res_new.value_begin = vb_next;
                    res_new.value_end   = OFFSET_W'(off);
                    case (phase_next)
                        PH_NAME, PH_NAME_AFTER_COMMA:
                        begin
                            if (!is_blank(c))
                            begin
                                if (c == CH_COMMA && phase_next == PH_NAME)
                                    phase_next = PH_NAME_AFTER_COMMA;
                                else if (c == CH_QUOTE)
                                begin
                                    nb_next = OFFSET_W'(off + 1'b1);
                                    phase_next = PH_IN_NAME;
                                end
                                else
                                    err = ST_NO_PARAM;
                            end
                        end
                        PH_IN_NAME:
                        begin
                            if (c == CH_QUOTE)
                            begin
                                ne_next = OFFSET_W'(off);
                                phase_next = PH_COLON;
                            end
                        end
                        PH_COLON:
                        begin
                            if (!is_blank(c))
                            begin
                                if (c == CH_COLON)
                                    phase_next = PH_VALUE;
                                else
                                    err = ST_NO_COLON;
                            end
                        end
                        PH_VALUE:
                        begin
                            if (!is_blank(c))
                            begin
                                if (c == CH_QUOTE)
                                begin
                                    vb_next = OFFSET_W'(off + 1'b1);
                                    phase_next = PH_STRING;
                                end
                                else if (c == CH_LBRACK)
                                begin
                                    vb_next = OFFSET_W'(off + 1'b1);
                                    phase_next = PH_ARRAY;
                                end
                                else if (c == CH_LBRACE)
                                begin
                                    vb_next = OFFSET_W'(off + 1'b1);
                                    depth_next = DEPTH_W'(1);
                                    phase_next = PH_STRUCT;
                                end
                                else if (c == CH_DOT || c == CH_MINUS ||
                                         (c >= CH_ZERO && c <= CH_NINE))
                                begin
                                    vb_next = OFFSET_W'(off);
                                    dot_next = (c == CH_DOT);
                                    phase_next = PH_NUMBER;
                                end
                                else
                                    err = ST_BAD_VALUE;
                            end
                        end
                        PH_STRING:
                        begin
                            if (c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE ||
                                c == CH_LBRACK || c == CH_RBRACK)
                                err = ST_DELIM_IN_STR;
                            else if (c == CH_QUOTE)
                            begin
                                res_new.value_kind = KIND_STRING;
                                have_new = 1'b1;
                                phase_next = PH_NAME;
                            end
                        end
                        PH_ARRAY:
                        begin
                            if (c == CH_RBRACK)
                            begin
                                res_new.value_kind = KIND_ARRAY;
                                have_new = 1'b1;
                                phase_next = PH_NAME;
                            end
                        end
                        PH_STRUCT:
                        begin
                            if (c == CH_LBRACE)
                            begin
                                if (depth_next >= DEPTH_W'(MAX_DEPTH))
                                    err = ST_OVERFLOW;
                                else
                                    depth_next = depth_next + 1'b1;
                            end
                            else if (c == CH_RBRACE)
                            begin
                                if (depth_next != '0)
                                    depth_next = depth_next - 1'b1;
                                if (depth_next == '0)
                                begin
                                    res_new.value_kind = KIND_STRUCT;
                                    have_new = 1'b1;
                                    phase_next = PH_NAME;
                                end
                            end
                        end
                        PH_NUMBER:
                        begin
                            if (c == CH_DOT)
                            begin
                                if (dot_next)
                                    err = ST_SECOND_DOT;
                                else
                                    dot_next = 1'b1;
                            end
                            else if (c < CH_ZERO || c > CH_NINE)
                            begin
                                res_new.value_kind = KIND_NUMBER;
                                have_new = 1'b1;
                                dot_next = 1'b0;
                                phase_next = PH_NAME;
                            end
                        end
                        default:
                            phase_next = PH_NAME;
                    endcase

                    if (have_new)
                    begin
                        res0 = res_new;
                        push_n = 2'd1;
                    end
                    if (err != ST_FOUND)
                    begin
                        res0 = fail_result(err);
                        push_n = 2'd1;
                        stopped_next = 1'b1;
                    end
                    else if (data.last_byte)
                    begin
                        // closing status follows the parameter when both occur
                        if (have_new)
                        begin
                            res1 = fail_result(end_status(phase_next));
                            push_n = 2'd2;
                        end
                        else
                        begin
                            res0 = fail_result(end_status(phase_next));
                            push_n = 2'd1;
                        end
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NAME;
            offset_reg  <= '0;
            nb_reg      <= '0;
            ne_reg      <= '0;
            vb_reg      <= '0;
            depth_reg   <= '0;
            dot_reg     <= 1'b0;
            stopped_reg <= 1'b0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            nb_reg      <= nb_next;
            ne_reg      <= ne_next;
            vb_reg      <= vb_next;
            depth_reg   <= depth_next;
            dot_reg     <= dot_next;
            stopped_reg <= stopped_next;
            wr_reg      <= wr_reg + QPTR_W'(push_n);
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg   <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_reg] <= res0;
        if (push_n == 2'd2)
            q_reg[wr_reg + 1'b1] <= res1;
    end

    assign result.valid        = count_reg != '0;
    assign result.status       = q_reg[rd_reg].status;
    assign result.value_kind   = q_reg[rd_reg].value_kind;
    assign result.name_begin   = q_reg[rd_reg].name_begin;
    assign result.name_end     = q_reg[rd_reg].name_end;
    assign result.value_begin  = q_reg[rd_reg].value_begin;
    assign result.value_end    = q_reg[rd_reg].value_end;
    assign result.final_result = q_reg[rd_reg].final_result;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_pair_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd2 |-> accept && data.last_byte)
        else $error("two results from a byte that does not end the buffer");

    a_silent_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stopped_reg && !data.first_byte |-> push_n == 2'd0)
        else $error("result produced after scanning stopped");

    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 && (res0.final_result || push_n == 2'd2) |=> stopped_reg)
        else $error("final result without stop");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import jkvs_pkg::*;

    localparam int FILL_NAME   = 0;
    localparam int FILL_STRING = 1;
    localparam int FILL_ARRAY  = 2;
    localparam int FILL_STRUCT = 3;

    localparam int PHASE_ITEMS = 225;
    localparam int DRAIN_LIMIT = 20000;

    class scan_scoreboard;
        result_t     pending_results[$];
        int          errors;
        phase_t      phase;
        int unsigned next_ofs;
        int unsigned name_b;
        int unsigned name_e;
        int unsigned value_b;
        int unsigned depth;
        bit          dot_seen;
        bit          halted;

        function new();
            errors = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            phase    = PH_NAME;
            next_ofs = 0;
            name_b   = 0;
            name_e   = 0;
            value_b  = 0;
            depth    = 0;
            dot_seen = 1'b0;
            halted   = 1'b0;
        endfunction

        function bit skippable(input logic [7:0] c);
            return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_NUL || c == CH_TAB;
        endfunction

        function bit is_digit(input logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function status_t stop_status(input phase_t ph);
            case (ph)
                PH_IN_NAME: return ST_NAME_OPEN;
                PH_COLON:   return ST_NO_COLON;
                PH_VALUE:   return ST_NO_VALUE;
                PH_STRING:  return ST_STRING_OPEN;
                PH_ARRAY:   return ST_ARRAY_OPEN;
                PH_STRUCT:  return ST_STRUCT_OPEN;
                PH_NUMBER:  return ST_NUMBER_OPEN;
                default:    return ST_NO_PARAM;
            endcase
        endfunction

        // offsets and kind only mean something for a found parameter
        function void add_result(input status_t st, input kind_t k, input int unsigned vend,
                                 input bit fin);
            result_t r;
            r = '0;
            r.status = st;
            if (st == ST_FOUND)
            begin
                r.value_kind  = k;
                r.name_begin  = offset_t'(name_b);
                r.name_end    = offset_t'(name_e);
                r.value_begin = offset_t'(value_b);
                r.value_end   = offset_t'(vend);
            end
            r.final_result = fin;
            pending_results.push_back(r);
        endfunction

        // returns 0 when the byte is ignored after a stop
        function bit note_byte(input logic [7:0] c, input logic first, input logic last);
            int unsigned ofs;
            status_t     err;
            if (first)
                restart_scan();
            else if (halted)
                return 1'b0;
            ofs = next_ofs;
            if (ofs >= MAX_BUFFER)
            begin
                add_result(ST_OVERFLOW, KIND_STRING, 0, 1'b1);
                halted = 1'b1;
                return 1'b1;
            end
            next_ofs = ofs + 1;
            err = ST_FOUND;
            case (phase)
                PH_NAME, PH_NAME_AFTER_COMMA:
                begin
                    if (!skippable(c))
                    begin
                        if (c == CH_COMMA && phase == PH_NAME)
                            phase = PH_NAME_AFTER_COMMA;
                        else if (c == CH_QUOTE)
                        begin
                            name_b = ofs + 1;
                            phase  = PH_IN_NAME;
                        end
                        else
                            err = ST_NO_PARAM;
                    end
                end
                PH_IN_NAME:
                begin
                    if (c == CH_QUOTE)
                    begin
                        name_e = ofs;
                        phase  = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (!skippable(c))
                    begin
                        if (c == CH_COLON)
                            phase = PH_VALUE;
                        else
                            err = ST_NO_COLON;
                    end
                end
                PH_VALUE:
                begin
                    if (!skippable(c))
                    begin
                        if (c == CH_QUOTE)
                        begin
                            value_b = ofs + 1;
                            phase   = PH_STRING;
                        end
                        else if (c == CH_LBRACK)
                        begin
                            value_b = ofs + 1;
                            phase   = PH_ARRAY;
                        end
                        else if (c == CH_LBRACE)
                        begin
                            value_b = ofs + 1;
                            depth   = 1;
                            phase   = PH_STRUCT;
                        end
                        else if (c == CH_DOT || c == CH_MINUS || is_digit(c))
                        begin
                            value_b  = ofs;
                            dot_seen = (c == CH_DOT);
                            phase    = PH_NUMBER;
                        end
                        else
                            err = ST_BAD_VALUE;
                    end
                end
                PH_STRING:
                begin
                    if (c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE ||
                        c == CH_LBRACK || c == CH_RBRACK)
                        err = ST_DELIM_IN_STR;
                    else if (c == CH_QUOTE)
                    begin
                        add_result(ST_FOUND, KIND_STRING, ofs, 1'b0);
                        phase = PH_NAME;
                    end
                end
                PH_ARRAY:
                begin
                    if (c == CH_RBRACK)
                    begin
                        add_result(ST_FOUND, KIND_ARRAY, ofs, 1'b0);
                        phase = PH_NAME;
                    end
                end
                PH_STRUCT:
                begin
                    if (c == CH_LBRACE)
                    begin
                        if (depth >= MAX_DEPTH)
                            err = ST_OVERFLOW;
                        else
                            depth++;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        if (depth > 0)
                            depth--;
                        if (depth == 0)
                        begin
                            add_result(ST_FOUND, KIND_STRUCT, ofs, 1'b0);
                            phase = PH_NAME;
                        end
                    end
                end
                PH_NUMBER:
                begin
                    if (c == CH_DOT)
                    begin
                        if (dot_seen)
                            err = ST_SECOND_DOT;
                        else
                            dot_seen = 1'b1;
                    end
                    else if (!is_digit(c))
                    begin
                        // the ending byte is swallowed by the number
                        add_result(ST_FOUND, KIND_NUMBER, ofs, 1'b0);
                        dot_seen = 1'b0;
                        phase    = PH_NAME;
                    end
                end
                default:
                    phase = PH_NAME;
            endcase
            if (err != ST_FOUND)
            begin
                add_result(err, KIND_STRING, 0, 1'b1);
                halted = 1'b1;
            end
            else if (last)
            begin
                add_result(stop_status(phase), KIND_STRING, 0, 1'b1);
                halted = 1'b1;
            end
            return 1'b1;
        endfunction

        function string show(input result_t r);
            return $sformatf("status=%0d kind=%0d name=%0d..%0d value=%0d..%0d final=%0b",
                             r.status, r.value_kind, r.name_begin, r.name_end,
                             r.value_begin, r.value_end, r.final_result);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            string   fields;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: transaction with nothing expected: %s", $time, show(got));
                return;
            end
            want = pending_results.pop_front();
            fields = "";
            if (got.status !== want.status)             fields = {fields, " status"};
            if (got.value_kind !== want.value_kind)     fields = {fields, " value_kind"};
            if (got.name_begin !== want.name_begin)     fields = {fields, " name_begin"};
            if (got.name_end !== want.name_end)         fields = {fields, " name_end"};
            if (got.value_begin !== want.value_begin)   fields = {fields, " value_begin"};
            if (got.value_end !== want.value_end)       fields = {fields, " value_end"};
            if (got.final_result !== want.final_result) fields = {fields, " final_result"};
            if (fields != "")
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch in%s\n  exp %s\n  got %s", $time, fields,
                             show(want), show(got));
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0)
            begin
                errors += pending_results.size();
                $display("%0d expected transactions never arrived", pending_results.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    jkvs_in_if  data_ch();
    jkvs_out_if result_ch();

    json_key_value_scanner_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch),
        .result (result_ch)
    );

    scan_scoreboard sb = new();

    int         src_idle_pct;
    int         sink_stall_pct;
    int         fed_count;
    logic [7:0] frame_q[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{status: result_ch.status, value_kind: result_ch.value_kind,
                              name_begin: result_ch.name_begin, name_end: result_ch.name_end,
                              value_begin: result_ch.value_begin,
                              value_end: result_ch.value_end,
                              final_result: result_ch.final_result});
    end

    task automatic put_byte(input logic [7:0] c, input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        data_ch.valid      <= 1'b1;
        data_ch.data_byte  <= c;
        data_ch.first_byte <= first;
        data_ch.last_byte  <= last;
        @(posedge clk);
        while (!data_ch.ready)
            @(posedge clk);
        if (sb.note_byte(c, first, last))
            fed_count++;
    endtask

    task automatic send_frame(input int last_at, input int restart_at);
        for (int i = 0; i < frame_q.size(); i++)
            put_byte(frame_q[i], (i == 0) || (i == restart_at), i == last_at);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endfunction

    function automatic void add_blanks(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            case ($urandom_range(4))
                0:       b = CH_SPACE;
                1:       b = CH_LF;
                2:       b = CH_CR;
                3:       b = CH_NUL;
                default: b = CH_TAB;
            endcase
            frame_q.push_back(b);
        end
    endfunction

    function automatic logic [7:0] digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // random byte that cannot close or break the current kind of text
    function automatic logic [7:0] filler(input int mode);
        logic [7:0] c;
        bit         bad;
        do
        begin
            c = 8'($urandom_range(255));
            case (mode)
                FILL_NAME:   bad = (c == CH_QUOTE);
                FILL_STRING: bad = c == CH_QUOTE || c == CH_COMMA || c == CH_LBRACE ||
                                   c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK;
                FILL_ARRAY:  bad = (c == CH_RBRACK);
                default:     bad = (c == CH_LBRACE || c == CH_RBRACE);
            endcase
        end
        while (bad);
        return c;
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(9))
            0:       return CH_QUOTE;
            1:       return CH_COLON;
            2:       return CH_COMMA;
            3:       return CH_DOT;
            4:       return CH_LBRACE;
            5:       return CH_RBRACE;
            6:       return CH_LBRACK;
            7:       return CH_RBRACK;
            8:       return digit();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void add_number();
        int         r;
        bit         dot;
        logic [7:0] c;
        r = $urandom_range(3);
        frame_q.push_back(r == 0 ? CH_MINUS : (r == 1 ? CH_DOT : digit()));
        dot = (r == 1);
        repeat ($urandom_range(0, 3))
        begin
            if (!dot && $urandom_range(4) == 0)
            begin
                frame_q.push_back(CH_DOT);
                dot = 1'b1;
            end
            else
                frame_q.push_back(digit());
        end
        if ($urandom_range(2) == 0)
            c = ($urandom_range(1) == 0) ? CH_COMMA : CH_SPACE;
        else
        begin
            do
                c = 8'($urandom_range(255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT);
        end
        frame_q.push_back(c);
    endfunction

    function automatic void add_param(input bit lead_comma);
        add_blanks($urandom_range(0, 2));
        if (lead_comma)
        begin
            frame_q.push_back(CH_COMMA);
            add_blanks($urandom_range(0, 1));
        end
        frame_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4))
            frame_q.push_back(filler(FILL_NAME));
        frame_q.push_back(CH_QUOTE);
        add_blanks($urandom_range(0, 1));
        frame_q.push_back(CH_COLON);
        add_blanks($urandom_range(0, 1));
        case ($urandom_range(3))
            0:
            begin
                frame_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                    frame_q.push_back(filler(FILL_STRING));
                frame_q.push_back(CH_QUOTE);
            end
            1:
            begin
                frame_q.push_back(CH_LBRACK);
                repeat ($urandom_range(0, 5))
                    frame_q.push_back(filler(FILL_ARRAY));
                frame_q.push_back(CH_RBRACK);
            end
            2:
            begin
                frame_q.push_back(CH_LBRACE);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        frame_q.push_back(CH_LBRACE);
                        frame_q.push_back(filler(FILL_STRUCT));
                        frame_q.push_back(CH_RBRACE);
                    end
                    else
                        frame_q.push_back(filler(FILL_STRUCT));
                end
                frame_q.push_back(CH_RBRACE);
            end
            default:
                add_number();
        endcase
    endfunction

    task automatic gen_frame();
        int pick;
        int last_at;
        int restart_at;
        int k;
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            // nesting right up to the depth limit, one above it at times
            add_text("\"d\":{");
            k = $urandom_range(61, 63);
            repeat (k)
                frame_q.push_back(CH_LBRACE);
            repeat (k + 1)
                frame_q.push_back(CH_RBRACE);
        end
        else if (pick < 85)
        begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
                add_param(($urandom_range(1) == 0) && (i > 0 || $urandom_range(3) == 0));
            if (pick >= 70)
                frame_q[$urandom_range(frame_q.size() - 1)] = special_byte();
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                frame_q.push_back(($urandom_range(1) == 0) ? special_byte()
                                                            : 8'($urandom_range(255)));
        end
        last_at = frame_q.size() - 1;
        case ($urandom_range(9))
            5, 6:
            begin
                add_blanks($urandom_range(1, 3));
                last_at = frame_q.size() - 1;
            end
            7:
                last_at = -1;
            8:
            begin
                // bytes after the stop are dropped
                repeat ($urandom_range(1, 3))
                    frame_q.push_back(8'($urandom_range(255)));
            end
            9:
            begin
                last_at = $urandom_range(frame_q.size() - 1);
                while (frame_q.size() > last_at + 1)
                    void'(frame_q.pop_back());
            end
            default:
                ;
        endcase
        restart_at = -1;
        if (frame_q.size() > 1 && $urandom_range(19) == 0)
            restart_at = $urandom_range(1, frame_q.size() - 1);
        send_frame(last_at, restart_at);
    endtask

    initial
    begin
        int goal;
        int waited;
        rst_n                = 1'b0;
        data_ch.valid        = 1'b0;
        data_ch.data_byte    = '0;
        data_ch.first_byte   = 1'b0;
        data_ch.last_byte    = 1'b0;
        src_idle_pct         = 0;
        sink_stall_pct       = 0;
        fed_count            = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every value kind, empty names, comma, nul blank, number ended on the last byte
        frame_q.delete();
        add_text("\"\":\"\"");
        frame_q.push_back(CH_NUL);
        add_text(",\"\":[]\"\":{}\"\":-9.");
        frame_q.push_back(8'hFF);
        send_frame(frame_q.size() - 1, -1);
        frame_q.delete();
        frame_q.push_back(CH_QUOTE);
        send_frame(0, -1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 56;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 56;
                end
                default:
                begin
                    src_idle_pct   = 35;
                    sink_stall_pct = 35;
                end
            endcase
            if (ph == 1)
            begin
                // string running past the end of the buffer
                frame_q.delete();
                add_text("\"n\":\"");
                while (frame_q.size() < MAX_BUFFER + 4)
                    frame_q.push_back(filler(FILL_STRING));
                send_frame(frame_q.size() - 1, -1);
            end
            goal = fed_count + PHASE_ITEMS;
            while (fed_count < goal)
                gen_frame();
        end
        data_ch.valid <= 1'b0;

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8)
            @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> json_key_value_scanner_core.f
hdl/jkvs_pkg.sv
hdl/jkvs_in_if.sv
hdl/jkvs_out_if.sv
hdl/json_key_value_scanner_core.sv
dv/tb.sv
